// ===== hw/rtl/kc_pkg.sv =====
`default_nettype none

package kc_pkg;

  typedef enum logic [1:0] {
    OP_PUSH  = 2'd0,
    OP_READ  = 2'd1,
    OP_RESET = 2'd2
  } opcode_e;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [1:0]  symbol;
    logic        gene_start;
    logic [15:0] kmer_index;
    logic        clear_after_read;
  } kc_req_t;

  typedef struct packed {
    logic [31:0] kmer_count;
    logic [31:0] total_kmers;
  } kc_rsp_t;

  localparam logic [3:0] KmerLengthReset = 4'd8;

endpackage

`default_nettype wire

// ===== hw/rtl/kmer_counter_unit.sv =====
// Reads: a read request's result passes through the s1 stage and then the output
// register; a stalled output holds the next read in s1.
// Throughput: one request per cycle while the output is not stalled and no sweep
// runs; a push and a read both cost one read of the count memory and at most one
// write-back, with forwarding of the last write. Reset (rst_ni): window, fill level
// and total clear at once; the count memory is then swept to zero, one entry per
// cycle (2**(SYMBOL_BITS*KMER_MAX) entries, 65536 by default), with no request accepted until the sweep ends.
`default_nettype none

module kmer_counter_unit #(
  parameter int SYMBOL_BITS = 2,
  parameter int KMER_MAX    = 8,
  parameter int COUNT_BITS  = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  kc_pkg::kc_req_t  in_req_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output kc_pkg::kc_rsp_t  out_rsp_o,
  input  logic             cfg_we_i,
  input  logic [3:0]       cfg_wdata_i
);

  import kc_pkg::*;

  localparam int TableBits  = SYMBOL_BITS * KMER_MAX;
  localparam int TableDepth = 2 ** TableBits;
  localparam int FillBits   = $clog2(KMER_MAX + 1);
  localparam int IdxExtBits = (TableBits > 16) ? TableBits : 16;
  localparam int SymExtBits = (SYMBOL_BITS > 2) ? SYMBOL_BITS : 2;
  localparam int CntExtBits = (COUNT_BITS > 32) ? COUNT_BITS : 32;
  localparam logic [31:0]           OutMax   = '1;
  localparam logic [COUNT_BITS-1:0] CountMax = '1;
  localparam logic [FillBits-1:0]   FillMax  = FillBits'(KMER_MAX);

  logic [COUNT_BITS-1:0] mem_q [TableDepth];

  logic [3:0]            kmer_length_q;
  logic [TableBits-1:0]  win_q, win_d;
  logic [FillBits-1:0]   fill_q, fill_d;
  logic [COUNT_BITS-1:0] total_q, total_d;

  logic                  clearing_q;
  logic [TableBits-1:0]  clr_addr_q;

  logic                  s1_valid_q;
  logic                  s1_read_q;
  logic                  s1_clear_q;
  logic [TableBits-1:0]  s1_idx_q;
  logic [31:0]           s1_total_q;
  logic [COUNT_BITS-1:0] rd_q;

  logic                  wb_valid_q;
  logic [TableBits-1:0]  wb_idx_q;
  logic [COUNT_BITS-1:0] wb_data_q;

  logic                  out_valid_q;
  kc_rsp_t               out_rsp_q;

  logic                  accept, stall, advance;
  logic                  issue;
  logic                  issue_read;
  logic [TableBits-1:0]  issue_idx;
  logic [FillBits-1:0]   k_eff;
  logic [TableBits-1:0]  kmask;
  logic [TableBits-1:0]  win_base;
  logic [FillBits-1:0]   fill_base;
  logic [IdxExtBits-1:0] rd_idx_ext;
  logic [SymExtBits-1:0] sym_ext;
  logic [CntExtBits-1:0] total_ext, cur_ext;
  logic [31:0]           total_clip, cur_clip;
  logic [COUNT_BITS-1:0] cur, new_val;
  logic                  wr_en;

  assign stall      = s1_valid_q && s1_read_q && out_valid_q && !out_ready_i;
  assign advance    = s1_valid_q && !stall;
  assign in_ready_o = !clearing_q && !stall;
  assign accept     = in_valid_i && in_ready_o;

  // clamp word length to 1..KMER_MAX
  always_comb begin
    if (kmer_length_q == 4'd0) begin
      k_eff = FillBits'(1);
    end else if (int'(kmer_length_q) > KMER_MAX) begin
      k_eff = FillMax;
    end else begin
      k_eff = FillBits'(kmer_length_q);
    end
    for (int i = 0; i < TableBits; i++) begin
      kmask[i] = (i < int'(k_eff) * SYMBOL_BITS);
    end
  end

  assign rd_idx_ext = IdxExtBits'(in_req_i.kmer_index);
  assign sym_ext    = SymExtBits'(in_req_i.symbol);
  assign total_ext  = CntExtBits'(total_q);
  assign total_clip = (total_ext > CntExtBits'(OutMax)) ? OutMax : total_ext[31:0];

  always_comb begin
    win_base   = in_req_i.gene_start ? '0 : win_q;
    fill_base  = in_req_i.gene_start ? '0 : fill_q;
    win_d      = win_q;
    fill_d     = fill_q;
    total_d    = total_q;
    issue      = 1'b0;
    issue_read = 1'b0;
    issue_idx  = rd_idx_ext[TableBits-1:0];
    case (in_req_i.opcode)
      OP_PUSH: begin
        win_d  = TableBits'({win_base, sym_ext[SYMBOL_BITS-1:0]});
        fill_d = (fill_base < FillMax) ? fill_base + FillBits'(1) : fill_base;
        if (fill_d >= k_eff) begin
          issue     = 1'b1;
          issue_idx = win_d & kmask;
          total_d   = (total_q == CountMax) ? total_q : total_q + COUNT_BITS'(1);
        end
      end
      OP_READ: begin
        issue      = 1'b1;
        issue_read = 1'b1;
      end
      OP_RESET: begin
        win_d   = '0;
        fill_d  = '0;
        total_d = '0;
      end
      default: ;
    endcase
  end

  // forward the last write-back over a stale memory read
  assign cur     = (wb_valid_q && (wb_idx_q == s1_idx_q)) ? wb_data_q : rd_q;
  assign cur_ext = CntExtBits'(cur);
  assign cur_clip = (cur_ext > CntExtBits'(OutMax)) ? OutMax : cur_ext[31:0];

  always_comb begin
    new_val = (cur == CountMax) ? cur : cur + COUNT_BITS'(1);
    wr_en   = advance && !s1_read_q;
    if (s1_read_q) begin
      new_val = '0;
      wr_en   = advance && s1_clear_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kmer_length_q <= KmerLengthReset;
      win_q         <= '0;
      fill_q        <= '0;
      total_q       <= '0;
      clearing_q    <= 1'b1;
      clr_addr_q    <= '0;
      s1_valid_q    <= 1'b0;
      wb_valid_q    <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        kmer_length_q <= cfg_wdata_i;
      end
      if (clearing_q) begin
        clr_addr_q <= clr_addr_q + TableBits'(1);
        if (clr_addr_q == '1) begin
          clearing_q <= 1'b0;
        end
      end
      if (accept) begin
        win_q      <= win_d;
        fill_q     <= fill_d;
        total_q    <= total_d;
        s1_valid_q <= issue;
      end else if (advance) begin
        s1_valid_q <= 1'b0;
      end
      if (wr_en) begin
        wb_valid_q <= 1'b1;
      end
      if (advance && s1_read_q) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_read_q  <= issue_read;
      s1_clear_q <= in_req_i.clear_after_read;
      s1_idx_q   <= issue_idx;
      s1_total_q <= total_clip;
      rd_q       <= mem_q[issue_idx];
    end
    if (wr_en) begin
      wb_idx_q  <= s1_idx_q;
      wb_data_q <= new_val;
    end
    if (advance && s1_read_q) begin
      out_rsp_q.kmer_count  <= cur_clip;
      out_rsp_q.total_kmers <= s1_total_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (clearing_q) begin
      mem_q[clr_addr_q] <= '0;
    end else if (wr_en) begin
      mem_q[s1_idx_q] <= new_val;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

endmodule

`default_nettype wire
